// ===== src/tsl_pkg.sv =====
// Package with the shared result types of the token stream lexer.
package tsl_pkg;

  // Token kinds carried on the result channel.
  typedef enum logic [3:0] {
    KIND_ID     = 4'd0,
    KIND_BOOL   = 4'd1,
    KIND_INT    = 4'd2,
    KIND_STRING = 4'd3,
    KIND_ASSIGN = 4'd4,
    KIND_PLUS   = 4'd5,
    KIND_MINUS  = 4'd6,
    KIND_STAR   = 4'd7,
    KIND_SLASH  = 4'd8,
    KIND_SEMI   = 4'd9,
    KIND_LPAREN = 4'd10,
    KIND_RPAREN = 4'd11,
    KIND_COMMA  = 4'd12,
    KIND_LBRACE = 4'd13,
    KIND_RBRACE = 4'd14,
    KIND_EOF    = 4'd15
  } tsl_kind_t;

  // One result item.
  typedef struct packed {
    tsl_kind_t  kind;
    logic [7:0] text_char;
    logic       has_char;
    logic       token_end;
    logic       last;
  } tsl_result_t;

  // Up to two result items produced by one input byte.
  typedef struct packed {
    logic        v0;
    logic        v1;
    tsl_result_t r0;
    tsl_result_t r1;
  } tsl_push_t;

  // Result queue depth and the free space one input byte may need.
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCountW  = $clog2(QDepth + 1);
  localparam int unsigned MaxPerIn = 2;

endpackage

// ===== src/tsl_if.sv =====
// Valid/ready channel interfaces for the lexer input bytes and result items.
interface tsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface tsl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] text_char;
  logic       has_char;
  logic       token_end;
  logic       last;

  modport source (output valid, output kind, output text_char, output has_char,
                  output token_end, output last, input ready);
  modport sink (input valid, input kind, input text_char, input has_char,
                input token_end, input last, output ready);
endinterface

// ===== src/token_stream_lexer_unit.sv =====
// Top level of the token stream lexer: core plus result queue.
//
//  channel | dir | payload                                       | handshake
//  in_chan | in  | in_char                                       | valid/ready
//  out_chan| out | kind, text_char, has_char, token_end, last    | valid/ready
//
// One byte is classified and its results queued in the cycle it is accepted.
// A byte causes zero, one or two result items; the result port moves one per cycle while the receiver is ready.
// Input is taken while the four-entry result queue has room for two items.
// Synchronous active-low reset empties the queue and returns to idle mode.
// A stalled result port fills the queue and then holds off the input.
module token_stream_lexer_unit import tsl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tsl_in_if.sink    in_chan,
  tsl_out_if.source out_chan
);

  logic        in_fire;
  logic        space_ok;
  tsl_push_t   push;
  tsl_result_t head;

  assign in_chan.ready = space_ok;
  assign in_fire       = in_chan.valid && space_ok;

  tsl_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_char (in_chan.in_char),
    .push    (push)
  );

  tsl_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_fire),
    .push       (push),
    .space_ok   (space_ok),
    .head_valid (out_chan.valid),
    .head_ready (out_chan.ready),
    .head       (head)
  );

  // Result payload.
  assign out_chan.kind      = head.kind;
  assign out_chan.text_char = head.text_char;
  assign out_chan.has_char  = head.has_char;
  assign out_chan.token_end = head.token_end;
  assign out_chan.last      = head.last;

endmodule

// ===== src/tsl_core.sv =====
// Lexer core: byte classification, mode and keyword tracking, result generation.
module tsl_core import tsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_char,
  output tsl_push_t  push
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ID   = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_STR  = 2'd3
  } mode_t;

  // Keyword tracking: 1..4 walk "true", 5..9 walk "false".
  localparam logic [3:0] PROG_NONE  = 4'd0;
  localparam logic [3:0] PROG_T     = 4'd1;
  localparam logic [3:0] PROG_TRUE  = 4'd4;
  localparam logic [3:0] PROG_F     = 4'd5;
  localparam logic [3:0] PROG_FALSE = 4'd9;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  mode_t      mode_r, mode_nxt;
  logic [3:0] prog_r, prog_nxt;

  logic        is_letter, is_digit, is_op, idle_pass;
  tsl_kind_t   op_kind;
  tsl_result_t char_res, idle_res;
  logic        idle_v;
  tsl_push_t   gen;

  function automatic tsl_result_t end_res(input tsl_kind_t k);
    tsl_result_t r;
    r           = '0;
    r.kind      = k;
    r.token_end = 1'b1;
    return r;
  endfunction

  function automatic logic [3:0] prog_step(input logic [3:0] p, input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (p)
      4'd1:    hit = (c == "r");
      4'd2:    hit = (c == "u");
      4'd3:    hit = (c == "e");
      4'd5:    hit = (c == "a");
      4'd6:    hit = (c == "l");
      4'd7:    hit = (c == "s");
      4'd8:    hit = (c == "e");
      default: hit = 1'b0;
    endcase
    return hit ? p + 4'd1 : PROG_NONE;
  endfunction

  // Character classes of the incoming byte.
  assign is_letter = ((in_char >= "a") && (in_char <= "z")) ||
                     ((in_char >= "A") && (in_char <= "Z"));
  assign is_digit  = (in_char >= "0") && (in_char <= "9");

  // Single-character operator decoder.
  always_comb begin
    is_op   = 1'b1;
    op_kind = KIND_ASSIGN;
    unique case (in_char)
      "=":     op_kind = KIND_ASSIGN;
      "+":     op_kind = KIND_PLUS;
      "-":     op_kind = KIND_MINUS;
      "*":     op_kind = KIND_STAR;
      "/":     op_kind = KIND_SLASH;
      ";":     op_kind = KIND_SEMI;
      "(":     op_kind = KIND_LPAREN;
      ")":     op_kind = KIND_RPAREN;
      ",":     op_kind = KIND_COMMA;
      "{":     op_kind = KIND_LBRACE;
      "}":     op_kind = KIND_RBRACE;
      default: is_op = 1'b0;
    endcase
  end

  // A plain text character result.
  always_comb begin
    char_res           = '0;
    char_res.text_char = in_char;
    char_res.has_char  = 1'b1;
  end

  // Mode update and result generation for one byte.
  always_comb begin
    mode_nxt  = mode_r;
    prog_nxt  = prog_r;
    gen       = '0;
    idle_pass = 1'b0;
    idle_res  = '0;
    idle_v    = 1'b0;

    unique case (mode_r)
      MODE_STR: begin
        if (in_char == CH_QUOTE) begin
          gen.v0   = 1'b1;
          gen.r0   = end_res(KIND_STRING);
          mode_nxt = MODE_IDLE;
        end else if (in_char == CH_NUL) begin
          gen.v0   = 1'b1;
          gen.r0   = end_res(KIND_STRING);
          gen.v1   = 1'b1;
          gen.r1   = end_res(KIND_EOF);
          mode_nxt = MODE_IDLE;
        end else begin
          gen.v0 = 1'b1;
          gen.r0 = char_res;
        end
      end
      MODE_ID: begin
        if (is_letter || is_digit) begin
          gen.v0   = 1'b1;
          gen.r0   = char_res;
          prog_nxt = prog_step(prog_r, in_char);
        end else begin
          gen.v0    = 1'b1;
          gen.r0    = end_res(((prog_r == PROG_TRUE) || (prog_r == PROG_FALSE)) ?
                              KIND_BOOL : KIND_ID);
          mode_nxt  = MODE_IDLE;
          prog_nxt  = PROG_NONE;
          idle_pass = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_digit) begin
          gen.v0 = 1'b1;
          gen.r0 = char_res;
        end else begin
          gen.v0    = 1'b1;
          gen.r0    = end_res(KIND_INT);
          mode_nxt  = MODE_IDLE;
          idle_pass = 1'b1;
        end
      end
      default: idle_pass = 1'b1;
    endcase

    // Handling between tokens, also for a byte that just closed a token.
    if (idle_pass) begin
      if (in_char == CH_NUL) begin
        idle_v   = 1'b1;
        idle_res = end_res(KIND_EOF);
      end else if (is_letter) begin
        idle_v   = 1'b1;
        idle_res = char_res;
        mode_nxt = MODE_ID;
        prog_nxt = (in_char == "t") ? PROG_T : ((in_char == "f") ? PROG_F : PROG_NONE);
      end else if (is_digit) begin
        idle_v   = 1'b1;
        idle_res = char_res;
        mode_nxt = MODE_NUM;
      end else if (in_char == CH_QUOTE) begin
        mode_nxt = MODE_STR;
      end else if (is_op) begin
        idle_v             = 1'b1;
        idle_res           = char_res;
        idle_res.kind      = op_kind;
        idle_res.token_end = 1'b1;
      end
      if (gen.v0) begin
        gen.v1 = idle_v;
        gen.r1 = idle_res;
      end else begin
        gen.v0 = idle_v;
        gen.r0 = idle_res;
      end
    end

    // Mark the final result of this byte.
    if (gen.v1) begin
      gen.r1.last = 1'b1;
    end else if (gen.v0) begin
      gen.r0.last = 1'b1;
    end
  end

  assign push = gen;

  // Mode and keyword state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      prog_r <= PROG_NONE;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      prog_r <= prog_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_prog_only_in_id: assert property (@(posedge clk) disable iff (!rst_n)
    (prog_r != PROG_NONE) |-> (mode_r == MODE_ID))
    else $error("keyword tracking active outside identifier mode");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && push.r1.last && !push.r0.last))
    else $error("second result without a first one or with a bad last flag");

  a_quote_closes_string: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (mode_r == MODE_STR) && (in_char == CH_QUOTE)) |=> (mode_r == MODE_IDLE))
    else $error("closing quote did not end the string");
`endif

endmodule

// ===== src/tsl_outq.sv =====
// Result queue: takes up to two items per cycle, hands out one per cycle while the reader is ready.
module tsl_outq import tsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_en,
  input  tsl_push_t   push,
  output logic        space_ok,
  output logic        head_valid,
  input  logic        head_ready,
  output tsl_result_t head
);

  tsl_result_t         entry_r [QDepth];
  logic [QPtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCountW-1:0]  count_r, count_nxt;
  logic                wr0, wr1, pop;

  // Room for the largest burst one input byte can cause.
  assign space_ok   = (count_r <= QCountW'(QDepth - MaxPerIn));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];

  assign wr0 = push_en && push.v0;
  assign wr1 = push_en && push.v1;
  assign pop = head_valid && head_ready;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(wr0) + QPtrW'(wr1);
    rd_ptr_nxt = rd_ptr_r + QPtrW'(pop);
    count_nxt  = count_r + QCountW'(wr0) + QCountW'(wr1) - QCountW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; the second item lands just after the first.
  always_ff @(posedge clk) begin
    if (wr0) begin
      entry_r[wr_ptr_r] <= push.r0;
    end
    if (wr1) begin
      entry_r[wr_ptr_r + QPtrW'(1)] <= push.r1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCountW'(QDepth))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr0 |-> (count_r <= QCountW'(QDepth - MaxPerIn)))
    else $error("push into a queue without room for a full burst");
`endif

endmodule

// ===== bench/tb_token_stream_lexer_unit.sv =====
// Testbench for the token stream lexer: directed and random text checked against a local predictor.
module tb_token_stream_lexer_unit;
  import tsl_pkg::*;

  localparam logic [7:0] END_OF_TEXT = 8'h00;
  localparam logic [7:0] QUOTE       = 8'h22;
  localparam logic [7:0] SPACE       = 8'h20;
  localparam logic [7:0] NEWLINE     = 8'h0A;

  // Keyword tracker values: nothing matched, first letter and full word.
  localparam logic [3:0] KW_NONE  = 4'd0;
  localparam logic [3:0] KW_T     = 4'd1;
  localparam logic [3:0] KW_TRUE  = 4'd4;
  localparam logic [3:0] KW_F     = 4'd5;
  localparam logic [3:0] KW_FALSE = 4'd9;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TARGET  = 1450;
  localparam int TOTAL_TARGET   = 1650;

  typedef enum logic [1:0] {LEX_IDLE, LEX_WORD, LEX_NUMBER, LEX_QUOTED} lex_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  tsl_in_if  in_chan ();
  tsl_out_if out_chan ();

  token_stream_lexer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #10 clk = ~clk;

  // Predictor state and the tokens still owed by the block.
  lex_mode_t   lex_mode    = LEX_IDLE;
  logic [3:0]  kw_progress = KW_NONE;
  tsl_result_t expected_tokens[$];
  int          mismatch_count = 0;
  int          accepted_bytes = 0;
  int          stall_cycles   = 0;

  // Knobs shared by the stimulus and the receiver.
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int receiver_hold  = 0;

  string operator_chars  = "=+-*/;(),{}";
  string keyword_forms[9] = '{"true", "false", "tru", "fals", "truer", "false7", "True",
                              "t", "f"};

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Maps a byte to its operator kind; returns 0 for anything else.
  function automatic bit operator_kind(logic [7:0] c, output tsl_kind_t k);
    k = KIND_ID;
    case (c)
      "=": k = KIND_ASSIGN;
      "+": k = KIND_PLUS;
      "-": k = KIND_MINUS;
      "*": k = KIND_STAR;
      "/": k = KIND_SLASH;
      ";": k = KIND_SEMI;
      "(": k = KIND_LPAREN;
      ")": k = KIND_RPAREN;
      ",": k = KIND_COMMA;
      "{": k = KIND_LBRACE;
      "}": k = KIND_RBRACE;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Advances the keyword tracker by one identifier character.
  function automatic logic [3:0] next_progress(logic [3:0] p, logic [7:0] c);
    string word;
    int    pos;
    word = (p >= KW_F) ? "false" : "true";
    pos  = (p >= KW_F) ? int'(p - KW_F) + 1 : int'(p - KW_T) + 1;
    if (p != KW_NONE && p != KW_TRUE && p != KW_FALSE && c == word[pos]) return p + 4'd1;
    return KW_NONE;
  endfunction

  function automatic tsl_result_t make_token(tsl_kind_t k, logic [7:0] ch, logic has,
                                             logic fin);
    tsl_result_t r;
    r.kind      = k;
    r.text_char = ch;
    r.has_char  = has;
    r.token_end = fin;
    r.last      = 1'b0;
    return r;
  endfunction

  // Works out the result items of one accepted byte and queues them.
  function automatic void predict_byte(logic [7:0] c);
    tsl_result_t items[$];
    tsl_kind_t   op;
    bit          is_op;
    bit          consumed;
    is_op    = operator_kind(c, op);
    consumed = 1'b0;
    accepted_bytes++;
    if (lex_mode == LEX_QUOTED) begin
      if (c == QUOTE || c == END_OF_TEXT) begin
        items.push_back(make_token(KIND_STRING, 8'd0, 1'b0, 1'b1));
        if (c == END_OF_TEXT) items.push_back(make_token(KIND_EOF, 8'd0, 1'b0, 1'b1));
        lex_mode = LEX_IDLE;
      end else begin
        items.push_back(make_token(KIND_ID, c, 1'b1, 1'b0));
      end
      consumed = 1'b1;
    end else if (lex_mode == LEX_WORD) begin
      if (is_letter(c) || is_digit(c)) begin
        kw_progress = next_progress(kw_progress, c);
        items.push_back(make_token(KIND_ID, c, 1'b1, 1'b0));
        consumed = 1'b1;
      end else begin
        items.push_back(make_token((kw_progress == KW_TRUE || kw_progress == KW_FALSE) ?
                                   KIND_BOOL : KIND_ID, 8'd0, 1'b0, 1'b1));
        lex_mode    = LEX_IDLE;
        kw_progress = KW_NONE;
      end
    end else if (lex_mode == LEX_NUMBER) begin
      if (is_digit(c)) begin
        items.push_back(make_token(KIND_ID, c, 1'b1, 1'b0));
        consumed = 1'b1;
      end else begin
        items.push_back(make_token(KIND_INT, 8'd0, 1'b0, 1'b1));
        lex_mode = LEX_IDLE;
      end
    end

    // The byte is handled as if it arrived between tokens.
    if (!consumed) begin
      if (c == END_OF_TEXT) begin
        items.push_back(make_token(KIND_EOF, 8'd0, 1'b0, 1'b1));
      end else if (is_letter(c)) begin
        lex_mode    = LEX_WORD;
        kw_progress = (c == "t") ? KW_T : ((c == "f") ? KW_F : KW_NONE);
        items.push_back(make_token(KIND_ID, c, 1'b1, 1'b0));
      end else if (is_digit(c)) begin
        lex_mode = LEX_NUMBER;
        items.push_back(make_token(KIND_ID, c, 1'b1, 1'b0));
      end else if (c == QUOTE) begin
        lex_mode = LEX_QUOTED;
      end else if (is_op) begin
        items.push_back(make_token(op, c, 1'b1, 1'b1));
      end
    end

    if (items.size() > 0) begin
      items[items.size() - 1].last = 1'b1;
    end
    foreach (items[i]) expected_tokens.push_back(items[i]);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Predicts each accepted byte, checks each accepted result and watches for a hang.
  always @(posedge clk) begin
    tsl_result_t want;
    if (!rst_n) begin
      lex_mode     = LEX_IDLE;
      kw_progress  = KW_NONE;
      stall_cycles = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) predict_byte(in_chan.in_char);
      if (out_chan.valid && out_chan.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("result item with no expectation: kind %0d text_char %0d",
                 out_chan.kind, out_chan.text_char);
          mismatch_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_chan.kind));
          check_field("text_char", want.text_char, out_chan.text_char);
          check_field("has_char", 8'(want.has_char), 8'(out_chan.has_char));
          check_field("token_end", 8'(want.token_end), 8'(out_chan.token_end));
          check_field("last", 8'(want.last), 8'(out_chan.last));
        end
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result receiver: random stall bursts, plus a long hold-off when one is requested.
  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_hold > 0) begin
        stall_left    = receiver_hold;
        receiver_hold = 0;
      end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offers one byte and returns in the step where it is accepted.
  task automatic send_byte(input logic [7:0] c);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_char <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Holds the input back until every owed token has come out.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int x;
    x = $urandom_range(0, 51);
    return (x < 26) ? 8'("a" + x) : 8'("A" + x - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Sends one mostly well-formed token, sometimes noise or an end of text.
  task automatic send_token();
    int         pick;
    string      word;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_byte(rand_letter());
      repeat ($urandom_range(0, 5))
        send_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
    end else if (pick < 32) begin
      word = keyword_forms[$urandom_range(0, 8)];
      for (int i = 0; i < word.len(); i++) send_byte(word[i]);
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 5)) send_byte(rand_digit());
    end else if (pick < 57) begin
      send_byte(QUOTE);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 7) == 0) begin
          c = $urandom_range(0, 1) ? SPACE : NEWLINE;
        end else begin
          c = 8'($urandom_range(1, 255));
          if (c == QUOTE) c = "q";
        end
        send_byte(c);
      end
      // An occasional string is left open and runs into what follows.
      if ($urandom_range(0, 9) != 0) send_byte(QUOTE);
    end else if (pick < 77) begin
      send_byte(operator_chars[$urandom_range(0, operator_chars.len() - 1)]);
    end else if (pick < 87) begin
      send_byte($urandom_range(0, 1) ? SPACE : NEWLINE);
    end else if (pick < 96) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(END_OF_TEXT);
    end
    if ($urandom_range(0, 1) == 0) send_byte($urandom_range(0, 1) ? SPACE : NEWLINE);
  endtask

  // Every operator, back to back.
  task automatic test_operators();
    for (int i = 0; i < operator_chars.len(); i++) send_byte(operator_chars[i]);
  endtask

  // Number then letter, unknown top byte, empty string, open string closed by end of
  // text, and a number right after the end of a text.
  task automatic test_special_cases();
    logic [7:0] text[12];
    text = '{"9", "a", 8'hFF, QUOTE, QUOTE, QUOTE, SPACE, NEWLINE, ";", END_OF_TEXT,
             "7", END_OF_TEXT};
    foreach (text[i]) send_byte(text[i]);
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    sender_idles  = 1'b0;
    receiver_hold = HOLD_CYCLES;
    repeat (20) send_token();
    sender_idles = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_text();
    while (accepted_bytes < RANDOM_TARGET) send_token();
    wait_drained();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    while (accepted_bytes < TOTAL_TARGET) send_token();
    send_byte(END_OF_TEXT);
    wait_drained();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.in_char <= END_OF_TEXT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_operators();
    test_special_cases();
    test_backpressure();
    test_random_text();
    test_steady_stream();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
